// ===== rtl/core/ycpad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycpad_pkg: shared types and constants of the pad color converter
// Matrix coefficient table, scale and offset constants, the reciprocal used
// for the final divide by 255, and the stage enable and lane setup structs.
// ----------------------------------------------------------------------------
package ycpad_pkg;

    // Field and datapath widths
    localparam int ChanW      = 8;    // input color channel
    localparam int CompW      = 16;   // output component
    localparam int CoefW      = 18;   // signed Q2.16 coefficient
    localparam int DotW       = 26;   // signed dot product of one matrix row
    localparam int ScaleW     = 17;   // signed scale factor (always positive)
    localparam int OffW       = 42;   // unsigned rounding and bias offset
    localparam int NumW       = 44;   // signed numerator before the divide
    localparam int QuotW      = 24;   // numerator / 2^16, in-range part
    localparam int FracBits   = 16;   // Q2.16 fraction bits
    localparam int QuoFullW   = NumW - 1 - FracBits;
    localparam int RecipW     = 26;
    localparam int ProdW      = QuotW + RecipW;
    localparam int RecipShift = 33;

    // Divide by 255*2^16: shift by 16, then multiply by ceil(2^33/255)
    localparam longint DenQ    = 16711680;
    localparam longint HalfDen = 8355840;
    localparam logic [RecipW-1:0] Recip = 26'd33686019;

    // Scale factors
    localparam logic signed [ScaleW-1:0] ScaleFull8    = 17'sd255;
    localparam logic signed [ScaleW-1:0] ScaleFull16   = 17'sd65535;
    localparam logic signed [ScaleW-1:0] ScaleLuma8    = 17'sd219;
    localparam logic signed [ScaleW-1:0] ScaleLuma16   = 17'sd56064;
    localparam logic signed [ScaleW-1:0] ScaleChroma8  = 17'sd224;
    localparam logic signed [ScaleW-1:0] ScaleChroma16 = 17'sd57344;

    // Offsets: rounding half, plus luma foot or chroma midpoint
    localparam logic [OffW-1:0] OffHalf     = OffW'(HalfDen);
    localparam logic [OffW-1:0] OffLuma8    = OffW'(16 * DenQ + HalfDen);
    localparam logic [OffW-1:0] OffLuma16   = OffW'(4096 * DenQ + HalfDen);
    localparam logic [OffW-1:0] OffChroma8  = OffW'(128 * DenQ + HalfDen);
    localparam logic [OffW-1:0] OffChroma16 = OffW'(32768 * DenQ + HalfDen);

    // Saturation: quotient limit (max+1)*255 and the max value itself
    localparam logic [QuotW-1:0] Limit8  = 24'd65280;
    localparam logic [QuotW-1:0] Limit16 = 24'd16711680;
    localparam logic [CompW-1:0] Max8    = 16'd255;
    localparam logic [CompW-1:0] Max16   = 16'd65535;

    // Default matrix choice by frame size
    localparam logic [13:0] WideMin = 14'd1280;
    localparam logic [13:0] TallMin = 14'd720;

    // Requested matrix codes
    localparam logic [7:0] Code709  = 8'd1;
    localparam logic [7:0] CodeFcc  = 8'd4;
    localparam logic [7:0] Code601a = 8'd5;
    localparam logic [7:0] Code601b = 8'd6;
    localparam logic [7:0] Code240m = 8'd7;

    typedef enum logic [1:0] {
        Mat709  = 2'd0,
        MatFcc  = 2'd1,
        Mat601  = 2'd2,
        Mat240m = 2'd3
    } matrix_t;

    typedef enum logic [2:0] {
        LayoutLuma = 3'd0,
        LayoutYuv  = 3'd1,
        LayoutYvu  = 3'd2,
        LayoutBgr  = 3'd3,
        LayoutRgb  = 3'd4
    } layout_t;

    typedef enum logic [7:0] {
        RegMatrix = 8'd0,
        RegRange  = 8'd1,
        RegDepth  = 8'd2,
        RegLayout = 8'd3,
        RegWidth  = 8'd4,
        RegHeight = 8'd5
    } reg_index_t;

    // Coefficients [matrix][row][channel], rows Y, Cb, Cr; channels R, G, B
    localparam logic signed [CoefW-1:0] CoefTab [4][3][3] = '{
        '{ '{ 18'sd13933,  18'sd46871,  18'sd4732 },
           '{ -18'sd7509,  -18'sd25259, 18'sd32768 },
           '{ 18'sd32768,  -18'sd29763, -18'sd3005 } },
        '{ '{ 18'sd19661,  18'sd38666,  18'sd7209 },
           '{ -18'sd11045, -18'sd21723, 18'sd32768 },
           '{ 18'sd32768,  -18'sd27619, -18'sd5149 } },
        '{ '{ 18'sd19595,  18'sd38470,  18'sd7471 },
           '{ -18'sd11058, -18'sd21710, 18'sd32768 },
           '{ 18'sd32768,  -18'sd27439, -18'sd5329 } },
        '{ '{ 18'sd13894,  18'sd45941,  18'sd5702 },
           '{ -18'sd7609,  -18'sd25159, 18'sd32768 },
           '{ 18'sd32768,  -18'sd29150, -18'sd3618 } }
    };

    // Load enables of the four lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // Per-lane arithmetic setup, derived from the range and depth registers
    typedef struct packed {
        logic signed [ScaleW-1:0] scale;
        logic [OffW-1:0]          offset;
        logic [QuotW-1:0]         limit;
        logic [CompW-1:0]         maxval;
    } lane_cfg_t;

endpackage

// ===== rtl/core/rgb_to_ycbcr_pad_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_pad_color: RGB to YCbCr pad color converter
// Converts one 8-bit RGB beat into three 8- or 16-bit components in the
// selected matrix, range and layout.
// ----------------------------------------------------------------------------
// The block takes one RGB beat per clock while the output is not held and
// returns one component beat for each, in order, through four arithmetic
// stages per lane (dot product, scale, clamp, reciprocal multiply) and one
// output register for the layout select. Every stage keeps its own valid
// bit, so a stall on m_tready fills empty stages first and s_tready drops
// only when all five hold data. Configuration writes are taken at any time
// (cfg_ready is always high) but must only be issued while no beat is in
// flight.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_pad_color
    import ycpad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input RGB stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // Output component stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // first[15:0], second[31:16], third[47:32]
    output logic [0:0]  m_tuser    // unsupported[0]
);

    localparam int Depth = 5;

    logic [7:0]        matrix_code_reg;
    logic              full_range_reg;
    logic              high_depth_reg;
    logic [2:0]        layout_reg;
    logic [13:0]       frame_width_reg;
    logic [13:0]       frame_height_reg;

    matrix_t           mat_sel;
    lane_cfg_t         luma_cfg, chroma_cfg;

    logic [Depth-1:0]  vld_reg, vld_next;
    logic [Depth-1:0]  rdy;
    stage_en_t         lane_en;

    logic [ChanW-1:0]  red_in, green_in, blue_in;
    logic [ChanW-1:0]  red_reg [4];
    logic [ChanW-1:0]  green_reg [4];
    logic [ChanW-1:0]  blue_reg [4];
    logic [CompW-1:0]  comp [3];

    logic [CompW-1:0]  rep_r, rep_g, rep_b;
    logic [47:0]       tdata_next, tdata_reg;
    logic              bad_next, bad_reg;

    assign red_in   = s_tdata[7:0];
    assign green_in = s_tdata[15:8];
    assign blue_in  = s_tdata[23:16];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_code_reg  <= '0;
            full_range_reg   <= 1'b0;
            high_depth_reg   <= 1'b0;
            layout_reg       <= LayoutYuv;
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                RegMatrix: matrix_code_reg  <= cfg_data[7:0];
                RegRange:  full_range_reg   <= cfg_data[0];
                RegDepth:  high_depth_reg   <= cfg_data[0];
                RegLayout: layout_reg       <= cfg_data[2:0];
                RegWidth:  frame_width_reg  <= cfg_data[13:0];
                RegHeight: frame_height_reg <= cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

    // Matrix choice, with the frame-size default for unknown codes
    always_comb begin
        unique case (matrix_code_reg)
            Code709:            mat_sel = Mat709;
            CodeFcc:            mat_sel = MatFcc;
            Code601a, Code601b: mat_sel = Mat601;
            Code240m:           mat_sel = Mat240m;
            default: begin
                mat_sel = (frame_width_reg >= WideMin || frame_height_reg >= TallMin)
                        ? Mat709 : Mat601;
            end
        endcase
    end

    // Lane setup from range and depth
    always_comb begin
        luma_cfg.limit    = high_depth_reg ? Limit16 : Limit8;
        luma_cfg.maxval   = high_depth_reg ? Max16 : Max8;
        chroma_cfg.limit  = luma_cfg.limit;
        chroma_cfg.maxval = luma_cfg.maxval;
        chroma_cfg.offset = high_depth_reg ? OffChroma16 : OffChroma8;
        if (full_range_reg) begin
            luma_cfg.scale    = high_depth_reg ? ScaleFull16 : ScaleFull8;
            chroma_cfg.scale  = luma_cfg.scale;
            luma_cfg.offset   = OffHalf;
        end else begin
            luma_cfg.scale    = high_depth_reg ? ScaleLuma16 : ScaleLuma8;
            chroma_cfg.scale  = high_depth_reg ? ScaleChroma16 : ScaleChroma8;
            luma_cfg.offset   = high_depth_reg ? OffLuma16 : OffLuma8;
        end
    end

    // Pipeline flow: a stage loads when it is empty or its successor moves
    always_comb begin
        rdy[Depth-1] = !vld_reg[Depth-1] || m_tready;
        for (int k = Depth - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < Depth; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready   = rdy[0];
    assign m_tvalid   = vld_reg[Depth-1];
    assign lane_en.s1 = rdy[0];
    assign lane_en.s2 = rdy[1];
    assign lane_en.s3 = rdy[2];
    assign lane_en.s4 = rdy[3];

    // Raw channels ride along for the copy layouts
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            red_reg[0]   <= red_in;
            green_reg[0] <= green_in;
            blue_reg[0]  <= blue_in;
        end
        for (int k = 1; k < 4; k++) begin
            if (rdy[k]) begin
                red_reg[k]   <= red_reg[k-1];
                green_reg[k] <= green_reg[k-1];
                blue_reg[k]  <= blue_reg[k-1];
            end
        end
    end

    // One lane per matrix row: Y, Cb, Cr
    for (genvar row = 0; row < 3; row++) begin : g_lane
        ycpad_lane u_lane (
            .aclk   (aclk),
            .en     (lane_en),
            .cfg    ((row == 0) ? luma_cfg : chroma_cfg),
            .coef_r (CoefTab[mat_sel][row][0]),
            .coef_g (CoefTab[mat_sel][row][1]),
            .coef_b (CoefTab[mat_sel][row][2]),
            .red    (red_in),
            .green  (green_in),
            .blue   (blue_in),
            .value  (comp[row])
        );
    end

    // Output stage: layout select
    assign rep_r = high_depth_reg ? {red_reg[3], red_reg[3]}     : {8'h00, red_reg[3]};
    assign rep_g = high_depth_reg ? {green_reg[3], green_reg[3]} : {8'h00, green_reg[3]};
    assign rep_b = high_depth_reg ? {blue_reg[3], blue_reg[3]}   : {8'h00, blue_reg[3]};

    always_comb begin
        bad_next = 1'b0;
        unique case (layout_reg)
            LayoutLuma: tdata_next = {16'h0000, 16'h0000, comp[0]};
            LayoutYuv:  tdata_next = {comp[2], comp[1], comp[0]};
            LayoutYvu:  tdata_next = {comp[1], comp[2], comp[0]};
            LayoutBgr:  tdata_next = {rep_r, rep_g, rep_b};
            LayoutRgb:  tdata_next = {rep_b, rep_g, rep_r};
            default: begin
                tdata_next = '0;
                bad_next   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[Depth-1]) begin
            tdata_reg <= tdata_next;
            bad_reg   <= bad_next;
        end
    end

    assign m_tdata    = tdata_reg;
    assign m_tuser[0] = bad_reg;

`ifndef ASSERT_OFF
    // An unknown layout always comes out with zero components
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("unsupported beat carries nonzero components");

    // An empty pipeline with nothing accepted cannot present a beat next cycle
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        ((vld_reg == '0) && !(s_tvalid && s_tready)) |=> !m_tvalid)
        else $error("output beat without an accepted input");

    // A full pipeline under output stall must refuse input
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&vld_reg) && !m_tready) |-> !s_tready)
        else $error("input accepted while every stage is held");
`endif

endmodule

// ===== rtl/core/ycpad_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycpad_lane: one output component of the color matrix
// Four register stages: dot product, scale and offset, clamp and shift,
// reciprocal multiply. The rounded, clamped value leaves from stage four.
// ----------------------------------------------------------------------------
module ycpad_lane
    import ycpad_pkg::*;
(
    input  logic                    aclk,
    input  stage_en_t               en,
    input  lane_cfg_t               cfg,
    input  logic signed [CoefW-1:0] coef_r,
    input  logic signed [CoefW-1:0] coef_g,
    input  logic signed [CoefW-1:0] coef_b,
    input  logic [ChanW-1:0]        red,
    input  logic [ChanW-1:0]        green,
    input  logic [ChanW-1:0]        blue,
    output logic [CompW-1:0]        value
);

    logic signed [DotW-1:0]  red_x, green_x, blue_x;
    logic signed [DotW-1:0]  cr_x, cg_x, cb_x;
    logic signed [DotW-1:0]  dot_next, dot_reg;
    logic signed [NumW-1:0]  num_next, num_reg;
    logic [QuoFullW-1:0]     quo_full;
    logic                    neg_next, neg_reg;
    logic                    sat_next, sat_reg;
    logic [QuotW-1:0]        quo_next, quo_reg;
    logic [ProdW-1:0]        prod_next, prod_reg;
    logic                    zero_reg;
    logic                    full_reg;

    // Stage 1: dot product of the channels with one matrix row
    assign red_x    = DotW'($signed({1'b0, red}));
    assign green_x  = DotW'($signed({1'b0, green}));
    assign blue_x   = DotW'($signed({1'b0, blue}));
    assign cr_x     = DotW'(coef_r);
    assign cg_x     = DotW'(coef_g);
    assign cb_x     = DotW'(coef_b);
    assign dot_next = red_x * cr_x + green_x * cg_x + blue_x * cb_x;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            dot_reg <= dot_next;
        end
    end

    // Stage 2: scale to the output range and add bias plus rounding half
    assign num_next = NumW'(dot_reg) * NumW'(cfg.scale)
                    + $signed({{(NumW - OffW){1'b0}}, cfg.offset});

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            num_reg <= num_next;
        end
    end

    // Stage 3: drop the fraction, flag negative and saturating numerators
    assign quo_full = num_reg[NumW-2:FracBits];
    assign neg_next = num_reg[NumW-1];
    assign sat_next = !neg_next
                    && (quo_full >= {{(QuoFullW - QuotW){1'b0}}, cfg.limit});
    assign quo_next = (neg_next || sat_next) ? '0 : quo_full[QuotW-1:0];

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            neg_reg <= neg_next;
            sat_reg <= sat_next;
            quo_reg <= quo_next;
        end
    end

    // Stage 4: divide by 255 through the reciprocal
    assign prod_next = ProdW'(quo_reg) * ProdW'(Recip);

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            prod_reg <= prod_next;
            zero_reg <= neg_reg;
            full_reg <= sat_reg;
        end
    end

    always_comb begin
        priority if (full_reg) begin
            value = cfg.maxval;
        end else if (zero_reg) begin
            value = '0;
        end else begin
            value = prod_reg[RecipShift+CompW-1:RecipShift];
        end
    end

endmodule

// ===== test/rgb_to_ycbcr_pad_color_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_pad_color_checker: scoreboard for the pad color converter
// Follows the register writes, predicts the component beat of every accepted
// RGB beat and compares the result stream against those predictions in order.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_pad_color_checker
    import ycpad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // first[15:0], second[31:16], third[47:32]
    input  logic [0:0]  m_tuser,   // unsupported[0]
    output int          mismatch_count,
    output int          beats_pending,
    output int          beats_checked
);

    // Divide by 255 * 2^16, with half of it added for round half up
    localparam longint Div255Q   = 16711680;
    localparam longint Round255Q = 8355840;

    // Frame size from which the default matrix is BT.709
    localparam logic [13:0] HdWidth  = 14'd1280;
    localparam logic [13:0] HdHeight = 14'd720;

    // Q2.16 coefficients [matrix][row][channel]: matrices 709, FCC, 601, 240M;
    // rows Y, Cb, Cr; channels R, G, B
    localparam int CoefQ [4][3][3] = '{
        '{ '{ 13933,  46871,  4732 }, '{ -7509,  -25259, 32768 },
           '{ 32768, -29763, -3005 } },
        '{ '{ 19661,  38666,  7209 }, '{ -11045, -21723, 32768 },
           '{ 32768, -27619, -5149 } },
        '{ '{ 19595,  38470,  7471 }, '{ -11058, -21710, 32768 },
           '{ 32768, -27439, -5329 } },
        '{ '{ 13894,  45941,  5702 }, '{ -7609,  -25159, 32768 },
           '{ 32768, -29150, -3618 } }
    };

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] second;
        logic [15:0] third;
        logic        unsupported;
    } components_t;

    // Shadow copy of the register file
    logic [7:0]  matrix_code;
    logic        full_range;
    logic        high_depth;
    logic [2:0]  layout_sel;
    logic [13:0] frame_width;
    logic [13:0] frame_height;

    components_t expected_components [$];

    // Requested code, or the size-based default for unknown codes
    function automatic matrix_t choose_matrix();
        case (matrix_code)
            Code709:            return Mat709;
            CodeFcc:            return MatFcc;
            Code601a, Code601b: return Mat601;
            Code240m:           return Mat240m;
            default:            return (frame_width >= HdWidth || frame_height >= HdHeight) ?
                                       Mat709 : Mat601;
        endcase
    endfunction

    // One matrix row: scale, offset, round half up, clamp to the depth
    function automatic logic [15:0] convert_row(logic [23:0] pix, matrix_t mat, int row,
                                                bit chroma);
        longint maxv;
        longint step;
        longint dot;
        longint num;
        longint quo;
        maxv = high_depth ? 65535 : 255;
        step = high_depth ? 256 : 1;
        dot  = longint'(pix[7:0])   * CoefQ[mat][row][0]
             + longint'(pix[15:8])  * CoefQ[mat][row][1]
             + longint'(pix[23:16]) * CoefQ[mat][row][2];
        if (full_range) begin
            num = maxv * dot + Round255Q;
            if (chroma)
                num += (maxv + 1) / 2 * Div255Q;
        end else if (chroma) begin
            num = step * (224 * dot + 128 * Div255Q) + Round255Q;
        end else begin
            num = step * (219 * dot + 16 * Div255Q) + Round255Q;
        end
        if (num < 0)
            return '0;
        quo = num / Div255Q;
        if (quo > maxv)
            quo = maxv;
        return quo[15:0];
    endfunction

    // Copy layouts: 16-bit mode repeats the byte
    function automatic logic [15:0] widen(logic [7:0] v);
        return high_depth ? {v, v} : {8'd0, v};
    endfunction

    function automatic components_t predict_components(logic [23:0] pix);
        components_t res;
        matrix_t     mat;
        logic [15:0] luma;
        logic [15:0] cb;
        logic [15:0] cr;
        mat  = choose_matrix();
        res  = '0;
        luma = convert_row(pix, mat, 0, 1'b0);
        cb   = convert_row(pix, mat, 1, 1'b1);
        cr   = convert_row(pix, mat, 2, 1'b1);
        case (layout_sel)
            LayoutLuma: res.first = luma;
            LayoutYuv: begin
                res.first  = luma;
                res.second = cb;
                res.third  = cr;
            end
            LayoutYvu: begin
                res.first  = luma;
                res.second = cr;
                res.third  = cb;
            end
            LayoutBgr: begin
                res.first  = widen(pix[23:16]);
                res.second = widen(pix[15:8]);
                res.third  = widen(pix[7:0]);
            end
            LayoutRgb: begin
                res.first  = widen(pix[7:0]);
                res.second = widen(pix[15:8]);
                res.third  = widen(pix[23:16]);
            end
            default: res.unsupported = 1'b1;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        if (mismatch_count < 40)
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Compare result beats first, then queue the prediction of the new pixel,
    // then take register writes so the prediction sees the old settings
    always @(posedge aclk) begin : watch
        components_t want;
        if (!aresetn) begin
            matrix_code  <= '0;
            full_range   <= 1'b0;
            high_depth   <= 1'b0;
            layout_sel   <= LayoutYuv;
            frame_width  <= '0;
            frame_height <= '0;
            expected_components.delete();
            mismatch_count = 0;
            beats_checked  = 0;
            beats_pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_components.size() == 0) begin
                    report_mismatch("result beat with no pixel pending", 0, longint'(m_tdata));
                end else begin
                    want = expected_components.pop_front();
                    if (m_tdata[15:0] !== want.first)
                        report_mismatch("first component", want.first, m_tdata[15:0]);
                    if (m_tdata[31:16] !== want.second)
                        report_mismatch("second component", want.second, m_tdata[31:16]);
                    if (m_tdata[47:32] !== want.third)
                        report_mismatch("third component", want.third, m_tdata[47:32]);
                    if (m_tuser[0] !== want.unsupported)
                        report_mismatch("unsupported flag", want.unsupported, m_tuser[0]);
                    beats_checked++;
                end
            end
            if (s_tvalid && s_tready)
                expected_components.push_back(predict_components(s_tdata));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    RegMatrix: matrix_code  <= cfg_data[7:0];
                    RegRange:  full_range   <= cfg_data[0];
                    RegDepth:  high_depth   <= cfg_data[0];
                    RegLayout: layout_sel   <= cfg_data[2:0];
                    RegWidth:  frame_width  <= cfg_data[13:0];
                    RegHeight: frame_height <= cfg_data[13:0];
                    default: ;
                endcase
            end
            beats_pending <= expected_components.size();
        end
    end

endmodule

// ===== test/rgb_to_ycbcr_pad_color_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_pad_color_test: top of the pad color converter testbench
// Drives corner colors, then random pixels under a series of register setups
// (every matrix code class, both ranges and depths, all layout codes, frame
// sizes around the HD bounds) with random gaps and output stalls; the checker
// beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_pad_color_test;
    import ycpad_pkg::*;

    localparam int ItemsPerSetup = 60;
    localparam int NumSetups     = 30;
    localparam int ForcedSetups  = 12;

    // Corner colors, sent with the reset settings
    localparam logic [23:0] CornerPix [10] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h808080, 24'h030201
    };

    // Fixed setups first: every code class, boundary sizes, every layout
    // (0, 2, 3, 8 and 255 are unsupported codes)
    localparam logic [7:0] SetupCode [ForcedSetups] = '{
        8'd0, Code709, CodeFcc, Code601a, Code601b, Code240m,
        8'd255, 8'd2, 8'd3, 8'd8, 8'd0, 8'd255
    };
    localparam logic [13:0] SetupWidth [ForcedSetups] = '{
        14'd0, 14'd16383, 14'd1279, 14'd1280, 14'd0, 14'd100,
        14'd1279, 14'd0, 14'd16383, 14'd1279, 14'd640, 14'd1280
    };
    localparam logic [13:0] SetupHeight [ForcedSetups] = '{
        14'd0, 14'd16383, 14'd719, 14'd0, 14'd720, 14'd100,
        14'd719, 14'd720, 14'd0, 14'd0, 14'd480, 14'd719
    };
    localparam logic [7:0] SupportedCode [5] = '{
        Code709, CodeFcc, Code601a, Code601b, Code240m
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // first[15:0], second[31:16], third[47:32]
    logic [0:0]  m_tuser;   // unsupported[0]

    int mismatch_count;
    int beats_pending;
    int beats_checked;
    int items_sent = 0;
    int setups     = 0;
    bit gaps_on    = 1'b0;
    bit stall_on   = 1'b0;

    rgb_to_ycbcr_pad_color u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rgb_to_ycbcr_pad_color_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending),
        .beats_checked  (beats_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("FAIL rgb_to_ycbcr_pad_color");
        $finish;
    end

    // Result side: ready bursts, with stalls mostly short and a few long
    initial begin : result_sink
        int hold;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (stall_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 40);
            end else begin
                m_tready <= 1'b1;
                hold = $urandom_range(1, 12);
            end
            repeat (hold) @(posedge aclk);
        end
    end

    // Channel value biased toward the ends of the range
    function automatic logic [7:0] pick_channel();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // One pixel beat, after an optional gap with junk data on the bus
    task automatic send_pixel(input logic [23:0] pix);
        int gap;
        int r;
        r   = $urandom_range(0, 9);
        gap = !gaps_on ? 0 : (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Hold off the sender until every pixel in flight has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Program all six registers; unused upper data bits carry noise
    task automatic apply_setup(input int idx);
        logic [7:0]  code;
        logic        fr;
        logic        hd;
        logic [2:0]  lay;
        logic [13:0] w;
        logic [13:0] h;
        if (idx < ForcedSetups) begin
            code = SetupCode[idx];
            w    = SetupWidth[idx];
            h    = SetupHeight[idx];
            lay  = 3'(idx);
            fr   = idx[0];
            hd   = idx[1];
        end else begin
            case ($urandom_range(0, 3))
                0, 1:    code = SupportedCode[$urandom_range(0, 4)];
                2:       code = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(8, 255));
                default: code = 8'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0:       w = 14'($urandom_range(1270, 1290));
                1:       w = 14'($urandom);
                default: w = 14'($urandom_range(0, 1279));
            endcase
            case ($urandom_range(0, 2))
                0:       h = 14'($urandom_range(710, 730));
                1:       h = 14'($urandom);
                default: h = 14'($urandom_range(0, 719));
            endcase
            lay = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
            fr  = 1'($urandom);
            hd  = 1'($urandom);
        end
        // index past the register list, which the block drops
        if ($urandom_range(0, 3) == 0)
            write_reg(8'($urandom_range(6, 255)), 16'($urandom));
        write_reg(RegMatrix, {8'($urandom), code});
        write_reg(RegRange,  {15'($urandom), fr});
        write_reg(RegDepth,  {15'($urandom), hd});
        write_reg(RegLayout, {13'($urandom), lay});
        write_reg(RegWidth,  {2'($urandom), w});
        write_reg(RegHeight, {2'($urandom), h});
        cfg_valid <= 1'b0;
        setups++;
    endtask

    initial begin : stimulus
        int drain_at;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corner colors under the reset settings
        foreach (CornerPix[i])
            send_pixel(CornerPix[i]);

        // Random pixels, one batch per setup
        for (int phase = 0; phase < NumSetups; phase++) begin
            drain_results();
            apply_setup(phase);
            gaps_on  = (phase % 4 != 1) && ($urandom_range(0, 9) < 8);
            stall_on = (phase % 4 != 1) && ($urandom_range(0, 9) < 8);
            drain_at = (phase == 0) ? ItemsPerSetup / 2 :
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, ItemsPerSetup - 1) : -1;
            for (int k = 0; k < ItemsPerSetup; k++) begin
                if (k == drain_at)
                    drain_results();
                send_pixel({pick_channel(), pick_channel(), pick_channel()});
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        $display("Run covered %0d pixels under %0d register setups plus the reset one,",
                 items_sent, setups);
        $display("with %0d component beats checked against prediction.", beats_checked);
        if (mismatch_count == 0 && beats_pending == 0)
            $display("PASS rgb_to_ycbcr_pad_color");
        else
            $display("FAIL rgb_to_ycbcr_pad_color");
        $finish;
    end

endmodule
